// ===== hw/rtl/cpt_pkg.sv =====
// Circle packing table: shared types, codes and constants.
// No dependencies; imported by cpt_ovl, the top level and the testbench.
`default_nettype none
package cpt_pkg;

  localparam int MAX_CIRCLES = 4096;
  localparam int COORD_BITS  = 16;
  localparam int AW          = $clog2(MAX_CIRCLES);
  localparam int CW          = $clog2(MAX_CIRCLES + 1);
  localparam int RW          = COORD_BITS + 2;

  localparam logic [11:0] STEP_RST   = 12'd98;
  localparam logic [15:0] THRESH_RST = 16'd197;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GROW   = 2'd1,
    CMD_CLEAN  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INSIDE = 2'd1,
    ST_FULL   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  localparam logic REG_DELTA  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic signed [RW-1:0]  r;
    logic                  frozen;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic insert;
    logic skip;
  } ovl_req_t;

  typedef struct packed {
    logic busy;
    logic valid;
    logic hit;
  } ovl_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cpt_intf.sv =====
// Circle packing table: command and response channel interfaces.
// No dependencies.
`default_nettype none
interface cpt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [11:0] index;
  modport source (output valid, cmd, pos_x, pos_y, index, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, index, output ready);
endinterface

interface cpt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        entry_x;
  logic [15:0]        entry_y;
  logic signed [16:0] entry_r;
  logic               entry_frozen;
  logic [12:0]        circle_count;
  modport source (output valid, status, entry_x, entry_y, entry_r, entry_frozen,
                  circle_count, input ready);
  modport sink (input valid, status, entry_x, entry_y, entry_r, entry_frozen,
                circle_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cpt_ram.sv =====
// Circle packing table: generic single-write, single-read RAM, registered read.
// No dependencies.
`default_nettype none
module cpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/cpt_ovl.sv =====
// Circle packing table: pipelined box and overlap test of one entry per cycle.
// Depends on cpt_pkg.
`default_nettype none
module cpt_ovl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cpt_pkg::ovl_req_t              req,
  input  wire cpt_pkg::entry_t                ent,
  input  wire logic [cpt_pkg::COORD_BITS-1:0] ref_x,
  input  wire logic [cpt_pkg::COORD_BITS-1:0] ref_y,
  input  wire logic signed [cpt_pkg::RW-1:0]  ref_r,
  output cpt_pkg::ovl_rsp_t                   rsp
);
  import cpt_pkg::*;

  localparam int BW = COORD_BITS + 4;
  localparam int DW = COORD_BITS + 1;
  localparam int SW = RW + 1;

  logic signed [BW-1:0] cx, cy, cr, px, py;
  logic box;
  logic signed [DW-1:0] dx, dy;
  logic signed [SW-1:0] s;

  logic va, ins_a, box_a, use_a;
  logic signed [DW-1:0] dx_a, dy_a;
  logic signed [SW-1:0] s_a;
  logic vb, ins_b, box_b, use_b;
  logic signed [2*DW-1:0] dx2, dy2;
  logic signed [2*SW-1:0] s2;
  logic vc, hit_c;
  logic [2*DW:0] dsum;

  always_comb begin
    cx  = $signed({4'b0, ent.x});
    cy  = $signed({4'b0, ent.y});
    cr  = $signed({{(BW-RW){ent.r[RW-1]}}, ent.r});
    px  = $signed({4'b0, ref_x});
    py  = $signed({4'b0, ref_y});
    box = (cx - cr < px) && (px < cx + cr) && (cy - cr < py) && (py < cy + cr);
    dx  = $signed({1'b0, ref_x}) - $signed({1'b0, ent.x});
    dy  = $signed({1'b0, ref_y}) - $signed({1'b0, ent.y});
    s   = $signed({ref_r[RW-1], ref_r}) + $signed({ent.r[RW-1], ent.r});
    dsum = {1'b0, dx2[2*DW-2:0]} + {1'b0, dy2[2*DW-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= req.valid;
      vb <= va;
      vc <= vb;
    end
    ins_a <= req.insert;
    box_a <= box;
    use_a <= !req.skip && (ent.r > 0);
    dx_a  <= dx;
    dy_a  <= dy;
    s_a   <= s;
    ins_b <= ins_a;
    box_b <= box_a;
    use_b <= use_a;
    dx2   <= dx_a * dx_a;
    dy2   <= dy_a * dy_a;
    s2    <= s_a * s_a;
    hit_c <= ins_b ? box_b
                   : (use_b && ({{(2*SW-2*DW-2){1'b0}}, dsum} < s2[2*SW-2:0]));
  end

  assign rsp.busy  = va | vb | vc;
  assign rsp.valid = vc;
  assign rsp.hit   = hit_c;
endmodule
`default_nettype wire

// ===== hw/rtl/circle_packing_table_unit.sv =====
// Circle packing table: top level, command sequencer, APB registers, response slot.
// Depends on cpt_pkg, cpt_intf, cpt_ram, cpt_ovl.
//
//  Channel  Dir  Transfer on
//  cmd_ch   in   cmd_ch.valid & cmd_ch.ready
//  rsp_ch   out  rsp_ch.valid & rsp_ch.ready
//  APB      in   psel & penable & pwrite (pready tied high)
//
// Insert, grow and cleanup walk the table through the single read port of the entry RAM.
// Grow pass: each unfrozen circle scans all others in turn.
// Reset clears the count and the response valid, returns the sequencer to idle and loads
// the register defaults; the RAM holds no reset state.
// A new command is taken as soon as the sequencer is idle, even while a response waits.
`default_nettype none
module circle_packing_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  cpt_cmd_if.sink          cmd_ch,
  cpt_rsp_if.source        rsp_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import cpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_INSWR, S_KREAD, S_KWAIT, S_KWRITE,
    S_CLEAN, S_CDRAIN, S_CSET, S_RD, S_RDW, S_FIN
  } state_t;

  state_t state;
  logic [11:0] step_size;
  logic [15:0] remove_threshold;
  logic [CW-1:0] count, j, k, w;
  logic [1:0] cmd_r;
  logic [COORD_BITS-1:0] px, py;
  logic [11:0] idx;
  entry_t cur, rdata, wdata;
  logic iss_valid, iss_skip, hit;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic keep, edge_blk;
  logic signed [RW+1:0] ex, ey, er;
  logic signed [RW-1:0] r_next;
  status_t res_status;
  entry_t res_ent;
  ovl_req_t oreq;
  ovl_rsp_t orsp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? {16'b0, remove_threshold}
                                           : {20'b0, step_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= STEP_RST;
      remove_threshold <= THRESH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DELTA:  step_size        <= pwdata[11:0];
        REG_THRESH: remove_threshold <= pwdata[15:0];
        default:    step_size        <= step_size;
      endcase
    end
  end

  assign keep = (rdata.r >= $signed({2'b0, remove_threshold}));
  always_comb begin
    ex = $signed({4'b0, rdata.x});
    ey = $signed({4'b0, rdata.y});
    er = $signed({{2{rdata.r[RW-1]}}, rdata.r});
    edge_blk = (ex + er >= (1 <<< COORD_BITS)) || (ex - er <= 0) ||
               (ey + er >= (1 <<< COORD_BITS)) || (ey - er <= 0);
    r_next = hit ? cur.r - $signed({6'b0, step_size})
                 : cur.r + $signed({6'b0, step_size});
  end

  always_comb begin
    we    = 1'b0;
    waddr = j[AW-1:0];
    wdata = rdata;
    raddr = j[AW-1:0];
    unique case (state)
      S_KREAD: raddr = k[AW-1:0];
      S_RD:    raddr = idx[AW-1:0];
      S_INSWR: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = '{x: px, y: py, r: '0, frozen: 1'b0};
      end
      S_KWRITE: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
        wdata = '{x: cur.x, y: cur.y, r: r_next, frozen: hit};
      end
      S_CLEAN, S_CDRAIN: begin
        we    = iss_valid && keep;
        waddr = w[AW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  cpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CIRCLES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign oreq.valid  = iss_valid && (cmd_r != CMD_CLEAN);
  assign oreq.insert = (cmd_r == CMD_INSERT);
  assign oreq.skip   = iss_skip;

  cpt_ovl u_ovl (
    .clk   (clk),
    .rst   (rst),
    .req   (oreq),
    .ent   (rdata),
    .ref_x ((cmd_r == CMD_INSERT) ? px : cur.x),
    .ref_y ((cmd_r == CMD_INSERT) ? py : cur.y),
    .ref_r (cur.r),
    .rsp   (orsp)
  );

  assign cmd_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      iss_valid     <= 1'b0;
      rsp_ch.valid  <= 1'b0;
    end else begin
      iss_valid <= (state == S_SCAN) || (state == S_CLEAN);
      if (orsp.valid && orsp.hit) hit <= 1'b1;
      if (we && (state == S_CLEAN || state == S_CDRAIN)) w <= w + 1'b1;
      if (rsp_ch.valid && rsp_ch.ready && (state != S_FIN)) rsp_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_ch.valid) begin
          cmd_r      <= cmd_ch.cmd;
          px         <= cmd_ch.pos_x;
          py         <= cmd_ch.pos_y;
          idx        <= cmd_ch.index;
          res_status <= ST_OK;
          res_ent    <= '0;
          hit        <= 1'b0;
          j          <= '0;
          k          <= '0;
          w          <= '0;
          unique case (cmd_ch.cmd)
            CMD_INSERT:
              if (count == CW'(MAX_CIRCLES)) begin
                res_status <= ST_FULL;
                state      <= S_FIN;
              end else begin
                state <= (count == '0) ? S_INSWR : S_SCAN;
              end
            CMD_GROW:  state <= (count == '0) ? S_FIN : S_KREAD;
            CMD_CLEAN: state <= (count == '0) ? S_FIN : S_CLEAN;
            default:
              if ({1'b0, cmd_ch.index} >= count) begin
                res_status <= ST_RANGE;
                state      <= S_FIN;
              end else begin
                state <= S_RD;
              end
          endcase
        end
        S_SCAN: begin
          iss_skip  <= (cmd_r == CMD_GROW) && (j == k);
          j         <= j + 1'b1;
          if (j == count - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: if (!iss_valid && !orsp.busy) begin
          if (cmd_r == CMD_GROW) begin
            state <= S_KWRITE;
          end else if (hit) begin
            res_status <= ST_INSIDE;
            state      <= S_FIN;
          end else begin
            state <= S_INSWR;
          end
        end
        S_INSWR: begin
          count <= count + 1'b1;
          state <= S_FIN;
        end
        S_KREAD: state <= S_KWAIT;
        S_KWAIT: begin
          cur <= rdata;
          if (rdata.frozen) begin
            k     <= k + 1'b1;
            state <= (k == count - 1'b1) ? S_FIN : S_KREAD;
          end else begin
            hit   <= edge_blk;
            j     <= '0;
            state <= S_SCAN;
          end
        end
        S_KWRITE: begin
          k     <= k + 1'b1;
          state <= (k == count - 1'b1) ? S_FIN : S_KREAD;
        end
        S_CLEAN: begin
          j         <= j + 1'b1;
          if (j == count - 1'b1) state <= S_CDRAIN;
        end
        S_CDRAIN: state <= S_CSET;
        S_CSET: begin
          count <= w;
          state <= S_FIN;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res_ent <= rdata;
          state   <= S_FIN;
        end
        S_FIN: if (!rsp_ch.valid || rsp_ch.ready) begin
          rsp_ch.valid        <= 1'b1;
          rsp_ch.status       <= res_status;
          rsp_ch.entry_x      <= res_ent.x;
          rsp_ch.entry_y      <= res_ent.y;
          rsp_ch.entry_r      <= res_ent.r[16:0];
          rsp_ch.entry_frozen <= res_ent.frozen;
          rsp_ch.circle_count <= count;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_CIRCLES)) else $error("circle count beyond table size");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    we |-> ({1'b0, waddr} <= count)) else $error("entry write beyond count");

  a_clean_compacts: assert property (@(posedge clk) disable iff (rst)
    (we && state == S_CDRAIN) |-> (w < count)) else $error("cleanup write past source");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!orsp.busy && !iss_valid))
    else $error("scan pipeline active while idle");
endmodule
`default_nettype wire

// ===== dv/tb_cpt_scoreboard.sv =====
// Scoreboard for the circle packing table: a predictor of the table and a queue of
// expected responses. Depends on cpt_pkg.
`default_nettype none
package tb_cpt_sb_pkg;
  import cpt_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic signed [16:0] er;
    logic               ef;
    logic [12:0]        cnt;
  } rsp_t;

  class table_predictor;
    int unsigned  cx[$];
    int unsigned  cy[$];
    int           cr[$];
    bit           cf[$];
    int unsigned  delta = 98;
    int unsigned  thresh = 197;
    rsp_t         pending[$];
    int           errors;

    function bit covered(longint px, longint py);
      foreach (cx[i]) begin
        if (longint'(cx[i]) - cr[i] < px && px < longint'(cx[i]) + cr[i] &&
            longint'(cy[i]) - cr[i] < py && py < longint'(cy[i]) + cr[i]) return 1;
      end
      return 0;
    endfunction

    function bit blocked(int k);
      longint x, y, r, dx, dy, s;
      x = cx[k];
      y = cy[k];
      r = cr[k];
      if (x + r >= 65536 || x - r <= 0 || y + r >= 65536 || y - r <= 0) return 1;
      foreach (cx[j]) begin
        if (j == k || cr[j] <= 0) continue;
        dx = x - longint'(cx[j]);
        dy = y - longint'(cy[j]);
        s  = r + cr[j];
        if (dx * dx + dy * dy < s * s) return 1;
      end
      return 0;
    endfunction

    function void note_command(logic [1:0] cmd, logic [15:0] px, logic [15:0] py,
                               logic [11:0] idx);
      rsp_t e;
      int   n;
      e = '0;
      case (cmd)
        CMD_INSERT: begin
          if (cx.size() >= MAX_CIRCLES) e.status = ST_FULL;
          else if (covered(px, py)) e.status = ST_INSIDE;
          else begin
            cx.insert(cx.size(), px);
            cy.insert(cy.size(), py);
            cr.insert(cr.size(), 0);
            cf.insert(cf.size(), 0);
          end
        end
        CMD_GROW: begin
          foreach (cx[i]) begin
            if (cf[i]) continue;
            if (blocked(i)) begin
              cr[i] -= delta;
              cf[i] = 1;
            end else cr[i] += delta;
          end
        end
        CMD_CLEAN: begin
          n = 0;
          foreach (cx[i]) begin
            if (longint'(cr[i]) < longint'(thresh)) continue;
            cx[n] = cx[i];
            cy[n] = cy[i];
            cr[n] = cr[i];
            cf[n] = cf[i];
            n++;
          end
          while (cx.size() > n) begin
            void'(cx.pop_back());
            void'(cy.pop_back());
            void'(cr.pop_back());
            void'(cf.pop_back());
          end
        end
        default: begin
          if (idx >= cx.size()) e.status = ST_RANGE;
          else begin
            e.ex = 16'(cx[idx]);
            e.ey = 16'(cy[idx]);
            e.er = 17'(cr[idx]);
            e.ef = cf[idx];
          end
        end
      endcase
      e.cnt = 13'(cx.size());
      pending.insert(pending.size(), e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("response with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d act %0d", e.status, a.status); errors++;
      end
      if (a.ex !== e.ex) begin
        $error("entry_x exp %0d act %0d", e.ex, a.ex); errors++;
      end
      if (a.ey !== e.ey) begin
        $error("entry_y exp %0d act %0d", e.ey, a.ey); errors++;
      end
      if (a.er !== e.er) begin
        $error("entry_r exp %0d act %0d", e.er, a.er); errors++;
      end
      if (a.ef !== e.ef) begin
        $error("entry_frozen exp %0d act %0d", e.ef, a.ef); errors++;
      end
      if (a.cnt !== e.cnt) begin
        $error("circle_count exp %0d act %0d", e.cnt, a.cnt); errors++;
      end
    endfunction
  endclass
endpackage
`default_nettype wire

// ===== dv/tb_top.sv =====
// Top of the circle packing table testbench: drives commands and register writes,
// checks every response against the scoreboard. Depends on cpt_pkg, cpt_intf, tb_cpt_scoreboard, RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpt_pkg::*;
  import tb_cpt_sb_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          src_idle, snk_idle;
  int          hold_off;
  int          hold_req, hold_seen;

  cpt_cmd_if cmd_ch ();
  cpt_rsp_if rsp_ch ();
  table_predictor sb;

  circle_packing_table_unit u_top (
    .clk(clk), .rst(rst), .cmd_ch(cmd_ch.sink), .rsp_ch(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // response side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready)
      sb.check_response({rsp_ch.status, rsp_ch.entry_x, rsp_ch.entry_y,
                         rsp_ch.entry_r, rsp_ch.entry_frozen, rsp_ch.circle_count});
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_off     <= 0;
      hold_seen    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_off     <= 300;
      rsp_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_cmd(cmd_t c, logic [15:0] x, logic [15:0] y, logic [11:0] idx);
    while ($urandom_range(99) < src_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.pos_x <= x;
    cmd_ch.pos_y <= y;
    cmd_ch.index <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_command(c, x, y, idx);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DELTA) sb.delta = val[11:0];
    else sb.thresh = val[15:0];
  endtask

  task automatic rand_insert();
    send_cmd(CMD_INSERT, 16'($urandom_range(65535)), 16'($urandom_range(65535)), '0);
  endtask

  task automatic rand_read();
    send_cmd(CMD_READ, '0, '0, (sb.cx.size() > 0 && $urandom_range(3) != 0) ?
             12'($urandom_range(sb.cx.size() - 1)) : 12'($urandom));
  endtask

  // one packing round: a few inserts, several grows, reads, sometimes a cleanup
  task automatic rand_round();
    int k;
    k = $urandom_range(6, 1);
    repeat (k) rand_insert();
    repeat ($urandom_range(5, 1))
      send_cmd(CMD_GROW, 16'($urandom), 16'($urandom), 12'($urandom));
    repeat ($urandom_range(3)) rand_read();
    if ($urandom_range(3) == 0)
      send_cmd(CMD_CLEAN, 16'($urandom), 16'($urandom), 12'($urandom));
  endtask

  initial begin
    int n;
    sb = new();
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cmd_ch.valid = 0; cmd_ch.cmd = CMD_INSERT; cmd_ch.pos_x = '0;
    cmd_ch.pos_y = '0; cmd_ch.index = '0;
    src_idle = 0; snk_idle = 0; hold_req = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges, every command, empty table, covered points
    send_cmd(CMD_READ, '0, '0, 12'd0);
    send_cmd(CMD_GROW, '0, '0, '0);
    send_cmd(CMD_CLEAN, '0, '0, '0);
    send_cmd(CMD_INSERT, 16'd0, 16'd0, '0);
    send_cmd(CMD_INSERT, 16'hFFFF, 16'hFFFF, '0);
    send_cmd(CMD_INSERT, 16'h8000, 16'h8000, 12'hFFF);
    send_cmd(CMD_INSERT, 16'h8000, 16'h8000, '0);
    repeat (3) send_cmd(CMD_GROW, '0, '0, '0);
    send_cmd(CMD_INSERT, 16'h8001, 16'h7FFF, '0);
    send_cmd(CMD_INSERT, 16'h8000 + 16'd294, 16'h8000, '0);
    send_cmd(CMD_READ, '0, '0, 12'd2);
    send_cmd(CMD_READ, '0, '0, 12'd0);
    send_cmd(CMD_READ, '0, '0, 12'hFFF);
    send_cmd(CMD_CLEAN, '0, '0, '0);
    send_cmd(CMD_READ, '0, '0, 12'd0);

    write_reg(REG_DELTA, 32'd4095);
    write_reg(REG_THRESH, 32'd0);
    send_cmd(CMD_INSERT, 16'h4000, 16'h4000, '0);
    send_cmd(CMD_GROW, '0, '0, '0);
    send_cmd(CMD_GROW, '0, '0, '0);
    send_cmd(CMD_READ, '0, '0, 12'd1);
    send_cmd(CMD_CLEAN, '0, '0, '0);

    write_reg(REG_DELTA, 32'd1);
    write_reg(REG_THRESH, 32'd65535);
    send_cmd(CMD_CLEAN, '0, '0, '0);
    write_reg(REG_DELTA, 32'd700);
    write_reg(REG_THRESH, 32'd197);

    // random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 20 : (ph == 1) ? 65 : 0;
      snk_idle = (ph == 0) ? 65 : (ph == 1) ? 20 : 0;
      n = 0;
      while (n < 32) begin
        if (sb.cx.size() > 24) send_cmd(CMD_CLEAN, '0, '0, '0);
        rand_round();
        n += 8;
      end
      if (ph == 1) begin
        hold_req++;
        repeat (8) rand_read();
      end
      drain();
      write_reg(REG_DELTA, $urandom_range(4095, 1));
      write_reg(REG_THRESH, $urandom_range(3) == 0 ? $urandom_range(65535) :
                $urandom_range(2000));
      if (sb.cx.size() > 16) begin
        write_reg(REG_THRESH, 32'd65535);
        send_cmd(CMD_CLEAN, '0, '0, '0);
        write_reg(REG_THRESH, 32'd197);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
